// ----- hdl/utf8_decode_display_width_macros.svh -----
// Assertion macros for the UTF-8 decoder with display width.
// Taken in by the RTL files that assert; relies on aclk and aresetn in scope.
`ifndef UTF8_DECODE_DISPLAY_WIDTH_MACROS_SVH
`define UTF8_DECODE_DISPLAY_WIDTH_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every edge outside reset.
`define UDW_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("utf8 decoder check failed");
// Checked at every edge, reset included.
`define UDW_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("utf8 decoder reset check failed");
`else
`define UDW_ASSERT(label, prop)
`define UDW_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- hdl/udw_pkg.sv -----
// Shared types, constants and the wide-character lookup for the UTF-8 decoder.
// No dependencies.
package udw_pkg;

    localparam int TOTAL_BITS   = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int CP_W         = 21;
    localparam int NB_W         = 3;
    localparam int DISPLAY_W    = 16;
    localparam int STATUS_W     = 3;
    localparam int OUT_FIELDS_W = CP_W + NB_W + 1 + DISPLAY_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [7:0] SURR_LEAD = 8'hED;
    localparam logic [7:0] SURR_MIN  = 8'hA0;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_SURR     = 3'd3,
        ST_BAD_CONT = 3'd4
    } status_t;

    localparam int NUM_WIDE = 8;
    localparam logic [CP_W-1:0] WIDE_LO [NUM_WIDE] = '{
        21'h1F600, 21'h1F300, 21'h1F680, 21'h02600,
        21'h02700, 21'h0FE00, 21'h1F900, 21'h1F1E6
    };
    localparam logic [CP_W-1:0] WIDE_HI [NUM_WIDE] = '{
        21'h1F64F, 21'h1F5FF, 21'h1F6FF, 21'h026FF,
        21'h027BF, 21'h0FE0F, 21'h1F9FF, 21'h1F1FF
    };

    // True when the code point takes two console columns.
    function automatic logic is_wide_point(input logic [CP_W-1:0] cp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_WIDE; i++) begin
            if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ----- hdl/utf8_decode_display_width.sv -----
// Top level of the UTF-8 decoder with console display width.
// Depends on udw_pkg and on utf8_decode_display_width_macros.svh.
//
// Usage: a string enters one byte per request on the s_ channel, with s_tlast
// high on the string's last byte. Each completed character gives one result
// request on the m_ channel with its code point, byte count, wide flag and the
// running display total. The first error of a string gives one result with
// its status in m_tuser; later bytes of that string give nothing until the
// last byte, whose result carries m_tlast and the latched status. A last byte
// always gives a result, and all string state clears after it.
// A result is presented on the edge after its byte is taken. The block takes
// one byte per cycle while the result register is free, set by the single decode
// stage between the sequence state registers and the result register.
// When the receiver stalls, the result register holds its request and
// s_tready falls until it is taken; s_tready is high whenever the result
// register is empty or being emptied in the same cycle.
// Reset (aresetn low, synchronous) clears the sequence state, the display
// total, the latched error and the result valid flag.
`include "utf8_decode_display_width_macros.svh"

module utf8_decode_display_width (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [udw_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] text_byte
    input  logic                            s_tlast,  // final_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [20:0] code_point, [23:21] char_bytes, [24] is_wide,
    // [40:25] display_total, [47:41] zero
    output logic [udw_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,  // string_end
    output logic [udw_pkg::STATUS_W-1:0]    m_tuser   // [2:0] status
);
    import udw_pkg::*;

    // Sequence and string state.
    logic [CP_W-1:0]       partial_point_reg, partial_point_next;
    logic [1:0]            bytes_remaining_reg, bytes_remaining_next;
    logic [NB_W-1:0]       sequence_length_reg, sequence_length_next;
    logic                  first_cont_reg, first_cont_next;
    logic                  surr_lead_reg, surr_lead_next;
    logic [TOTAL_BITS-1:0] running_width_reg, running_width_next;
    status_t               error_latched_reg, error_latched_next;

    // Result register.
    logic                  m_tvalid_reg;
    logic [CP_W-1:0]       code_point_reg, code_point_next;
    logic [NB_W-1:0]       char_bytes_reg, char_bytes_next;
    logic                  is_wide_reg, is_wide_next;
    logic [DISPLAY_W-1:0]  display_total_reg, display_total_next;
    logic                  string_end_reg;
    status_t               status_reg;

    logic                  s_accept;
    logic                  have_result;
    logic                  done;
    status_t               err;
    logic [TOTAL_BITS:0]   width_sum;
    logic [7:0]            b;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign b        = s_tdata;

    // Decode one byte against the current sequence state.
    always_comb begin
        partial_point_next   = partial_point_reg;
        bytes_remaining_next = bytes_remaining_reg;
        sequence_length_next = sequence_length_reg;
        first_cont_next      = first_cont_reg;
        surr_lead_next       = surr_lead_reg;
        running_width_next   = running_width_reg;
        error_latched_next   = error_latched_reg;
        have_result          = 1'b0;
        done                 = 1'b0;
        err                  = ST_OK;
        code_point_next      = '0;
        char_bytes_next      = '0;
        is_wide_next         = 1'b0;
        width_sum            = '0;

        if (error_latched_reg != ST_OK) begin
            // Bytes after an error are dropped; only the last byte reports.
            have_result = s_tlast;
        end else if (bytes_remaining_reg == 2'd0) begin
            priority if (!b[7]) begin
                code_point_next = CP_W'(b);
                char_bytes_next = NB_W'(1);
                done            = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                partial_point_next   = CP_W'(b[4:0]);
                bytes_remaining_next = 2'd1;
                sequence_length_next = NB_W'(2);
            end else if (b[7:4] == 4'b1110) begin
                partial_point_next   = CP_W'(b[3:0]);
                bytes_remaining_next = 2'd2;
                sequence_length_next = NB_W'(3);
            end else if (b[7:3] == 5'b11110) begin
                partial_point_next   = CP_W'(b[2:0]);
                bytes_remaining_next = 2'd3;
                sequence_length_next = NB_W'(4);
            end else begin
                err = ST_BAD_LEAD;
            end
            first_cont_next = (bytes_remaining_next != 2'd0);
            surr_lead_next  = (b == SURR_LEAD);
        end else begin
            // The continuation tag check comes before the surrogate check.
            priority if ((b & CONT_MASK) != CONT_TAG) begin
                err = ST_BAD_CONT;
            end else if (first_cont_reg && surr_lead_reg && b >= SURR_MIN) begin
                err = ST_SURR;
            end else begin
                partial_point_next   = {partial_point_reg[CP_W-7:0], b[5:0]};
                bytes_remaining_next = bytes_remaining_reg - 2'd1;
                first_cont_next      = 1'b0;
                if (bytes_remaining_reg == 2'd1) begin
                    code_point_next      = partial_point_next;
                    char_bytes_next      = sequence_length_reg;
                    done                 = 1'b1;
                    partial_point_next   = '0;
                    bytes_remaining_next = 2'd0;
                    sequence_length_next = '0;
                    surr_lead_next       = 1'b0;
                end
            end
        end

        if (done) begin
            is_wide_next = is_wide_point(code_point_next);
            width_sum    = {1'b0, running_width_reg}
                         + (is_wide_next ? (TOTAL_BITS+1)'(2) : (TOTAL_BITS+1)'(1));
            // Saturate at the largest value the total can hold.
            running_width_next = width_sum[TOTAL_BITS] ? '1
                                                       : width_sum[TOTAL_BITS-1:0];
            have_result        = 1'b1;
        end

        if (err != ST_OK) begin
            error_latched_next   = err;
            partial_point_next   = '0;
            bytes_remaining_next = 2'd0;
            sequence_length_next = '0;
            first_cont_next      = 1'b0;
            surr_lead_next       = 1'b0;
            have_result          = 1'b1;
        end else if (s_tlast && error_latched_reg == ST_OK && bytes_remaining_next != 2'd0) begin
            error_latched_next = ST_TRUNC;
            have_result        = 1'b1;
        end

        if (s_tlast) begin
            have_result = 1'b1;
        end

        display_total_next = DISPLAY_W'(running_width_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_point_reg   <= '0;
            bytes_remaining_reg <= 2'd0;
            sequence_length_reg <= '0;
            first_cont_reg      <= 1'b0;
            surr_lead_reg       <= 1'b0;
            running_width_reg   <= '0;
            error_latched_reg   <= ST_OK;
        end else if (s_accept) begin
            if (s_tlast) begin
                // The string is over: back to the reset state.
                partial_point_reg   <= '0;
                bytes_remaining_reg <= 2'd0;
                sequence_length_reg <= '0;
                first_cont_reg      <= 1'b0;
                surr_lead_reg       <= 1'b0;
                running_width_reg   <= '0;
                error_latched_reg   <= ST_OK;
            end else begin
                partial_point_reg   <= partial_point_next;
                bytes_remaining_reg <= bytes_remaining_next;
                sequence_length_reg <= sequence_length_next;
                first_cont_reg      <= first_cont_next;
                surr_lead_reg       <= surr_lead_next;
                running_width_reg   <= running_width_next;
                error_latched_reg   <= error_latched_next;
            end
        end
    end

    // Result valid flag; the payload loads on the same condition.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= have_result;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && have_result) begin
            code_point_reg    <= code_point_next;
            char_bytes_reg    <= char_bytes_next;
            is_wide_reg       <= is_wide_next;
            display_total_reg <= display_total_next;
            string_end_reg    <= s_tlast;
            status_reg        <= error_latched_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({display_total_reg, is_wide_reg,
                                    char_bytes_reg, code_point_reg});
    assign m_tlast  = string_end_reg;
    assign m_tuser  = status_reg;

    // A completed character never carries an error status.
    `UDW_ASSERT(a_char_ok, m_tvalid_reg && char_bytes_reg != '0 |-> status_reg == ST_OK)
    // Results without a character carry no code point and no wide flag.
    `UDW_ASSERT(a_empty_zero, m_tvalid_reg && char_bytes_reg == '0 |-> code_point_reg == '0 && !is_wide_reg)
    // Every wide range lies at or above the three-byte forms.
    `UDW_ASSERT(a_wide_len, m_tvalid_reg && is_wide_reg |-> char_bytes_reg >= NB_W'(3))
    // An open sequence means no error has been latched.
    `UDW_ASSERT(a_seq_no_err, bytes_remaining_reg != 2'd0 |-> error_latched_reg == ST_OK)
    // A taken last byte leaves all string state clear.
    `UDW_ASSERT(a_last_clears, s_accept && s_tlast |=> running_width_reg == '0 && error_latched_reg == ST_OK && bytes_remaining_reg == 2'd0)
    // Reset empties the result register.
    `UDW_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid_reg)

endmodule

// ----- sim/utf8_decode_display_width_tb.sv -----
// Self-checking testbench for the UTF-8 decoder with console display width.
// Depends on udw_pkg and on the utf8_decode_display_width RTL top level.
`timescale 1ns / 1ps

module utf8_decode_display_width_tb;
    import udw_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1000000;

    // One expected result request, split into the fields the block reports.
    typedef struct {
        logic [CP_W-1:0]      code_point;
        logic [NB_W-1:0]      char_bytes;
        logic                 is_wide;
        logic [DISPLAY_W-1:0] display_total;
        logic                 string_end;
        status_t              status;
    } char_result_t;

    // Holds its own decoder state, turns each accepted byte into the result
    // it should cause, and checks results against the oldest expectation.
    class utf8_width_scoreboard;
        char_result_t  pending_chars[$];
        int            fails;
        logic [20:0]   partial;
        logic [1:0]    remaining;
        logic [2:0]    seq_len;
        bit            first_cont;
        bit            ed_lead;
        longint        columns;
        status_t       latched;

        function new();
            fails = 0;
            reset_text();
        endfunction

        function void clear_seq();
            partial    = '0;
            remaining  = '0;
            seq_len    = '0;
            first_cont = 1'b0;
            ed_lead    = 1'b0;
        endfunction

        function void reset_text();
            clear_seq();
            columns = 0;
            latched = ST_OK;
        endfunction

        // Two columns for the emoji and symbol blocks, one otherwise.
        function bit double_column(logic [20:0] cp);
            return (cp >= 21'h1F300 && cp <= 21'h1F64F) ||
                   (cp >= 21'h1F680 && cp <= 21'h1F6FF) ||
                   (cp >= 21'h1F900 && cp <= 21'h1F9FF) ||
                   (cp >= 21'h1F1E6 && cp <= 21'h1F1FF) ||
                   (cp >= 21'h02600 && cp <= 21'h027BF) ||
                   (cp >= 21'h0FE00 && cp <= 21'h0FE0F);
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            char_result_t r;
            bit           emit;
            bit           done;
            bit           wide;
            logic [20:0]  cp;
            logic [2:0]   nb;
            status_t      err;
            longint       top;
            emit = 1'b0;
            done = 1'b0;
            wide = 1'b0;
            cp   = '0;
            nb   = '0;
            err  = ST_OK;
            top  = (longint'(1) << TOTAL_BITS) - 1;
            if (latched != ST_OK) begin
                // Bytes after an error only matter when they end the text.
                if (!fin) return;
                emit = 1'b1;
            end else if (remaining == 0) begin
                if (b[7] == 1'b0) begin
                    cp   = {14'd0, b[6:0]};
                    nb   = 3'd1;
                    done = 1'b1;
                end else if (b[7:5] == 3'b110) begin
                    partial = {16'd0, b[4:0]}; remaining = 2'd1; seq_len = 3'd2;
                end else if (b[7:4] == 4'b1110) begin
                    partial = {17'd0, b[3:0]}; remaining = 2'd2; seq_len = 3'd3;
                end else if (b[7:3] == 5'b11110) begin
                    partial = {18'd0, b[2:0]}; remaining = 2'd3; seq_len = 3'd4;
                end else begin
                    err = ST_BAD_LEAD;
                end
                first_cont = (remaining != 0);
                ed_lead    = (b == SURR_LEAD);
            end else begin
                if ((b & CONT_MASK) != CONT_TAG) begin
                    err = ST_BAD_CONT;
                end else if (first_cont && ed_lead && b >= SURR_MIN) begin
                    err = ST_SURR;
                end else begin
                    partial    = {partial[14:0], b[5:0]};
                    remaining  = remaining - 2'd1;
                    first_cont = 1'b0;
                    if (remaining == 0) begin
                        cp   = partial;
                        nb   = seq_len;
                        done = 1'b1;
                        clear_seq();
                    end
                end
            end
            if (done) begin
                wide    = double_column(cp);
                columns = columns + (wide ? 2 : 1);
                if (columns > top) columns = top;
                emit = 1'b1;
            end
            if (err != ST_OK) begin
                latched = err;
                clear_seq();
                emit = 1'b1;
            end else if (fin && latched == ST_OK && remaining != 0) begin
                latched = ST_TRUNC;
                emit = 1'b1;
            end
            if (fin) emit = 1'b1;
            if (!emit) return;
            r.code_point    = cp;
            r.char_bytes    = nb;
            r.is_wide       = wide;
            r.display_total = columns[DISPLAY_W-1:0];
            r.string_end    = fin;
            r.status        = latched;
            pending_chars.push_back(r);
            if (fin) reset_text();
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic fin,
                                   logic [STATUS_W-1:0] stat);
            char_result_t e;
            if (pending_chars.size() == 0) begin
                $error("result request with no character pending: tdata %0h", data);
                fails++;
                return;
            end
            e = pending_chars.pop_front();
            if (data[20:0] !== e.code_point) begin
                $error("code_point: expected %0h, got %0h", e.code_point, data[20:0]);
                fails++;
            end
            if (data[23:21] !== e.char_bytes) begin
                $error("char_bytes: expected %0d, got %0d", e.char_bytes, data[23:21]);
                fails++;
            end
            if (data[24] !== e.is_wide) begin
                $error("is_wide: expected %0d, got %0d", e.is_wide, data[24]);
                fails++;
            end
            if (data[40:25] !== e.display_total) begin
                $error("display_total: expected %0d, got %0d", e.display_total,
                       data[40:25]);
                fails++;
            end
            if (fin !== e.string_end) begin
                $error("string_end: expected %0d, got %0d", e.string_end, fin);
                fails++;
            end
            if (stat !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, stat);
                fails++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [STATUS_W-1:0]    m_tuser;

    utf8_width_scoreboard sb;
    logic [7:0] text_q[$];       // bytes of the text being built
    int         src_idle_pct;    // chance per cycle that the sender holds off
    int         sink_idle_pct;   // chance per cycle that the receiver stalls
    int         bytes_sent;
    int         cycles;

    utf8_decode_display_width u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // The receiver decides at each falling edge whether it takes the next
    // result request.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Both handshakes are sampled at the rising edge, before the block's own
    // registers move. A byte taken here is turned into its expected result;
    // the block answers no earlier than the next edge, so the order within
    // this block does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one byte at a falling edge, after a random hold-off, and returns
    // once the rising edge that accepts it has passed.
    task automatic push_text_byte(input logic [7:0] b, input logic fin);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Sends the bytes built up in text_q as one text, the last one flagged.
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            push_text_byte(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    // Drops the request and holds off until every expected result has been taken.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Encodes cp into len bytes; a longer form than needed is allowed and
    // gives an overlong sequence that the block decodes as written.
    function automatic void append_char(logic [20:0] cp, int len);
        case (len)
            1: text_q.push_back({1'b0, cp[6:0]});
            2: begin
                text_q.push_back({3'b110, cp[10:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                text_q.push_back({4'b1110, cp[15:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                text_q.push_back({5'b11110, cp[20:18]});
                text_q.push_back({2'b10, cp[17:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // A code point in or just outside one of the double-column blocks, so
    // both sides of every boundary are hit.
    function automatic void append_wide_char();
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        case ($urandom_range(5))
            0:       begin lo = 21'h1F300; hi = 21'h1F64F; end
            1:       begin lo = 21'h1F680; hi = 21'h1F6FF; end
            2:       begin lo = 21'h1F900; hi = 21'h1F9FF; end
            3:       begin lo = 21'h1F1E6; hi = 21'h1F1FF; end
            4:       begin lo = 21'h02600; hi = 21'h027BF; end
            default: begin lo = 21'h0FE00; hi = 21'h0FE0F; end
        endcase
        case ($urandom_range(5))
            0:       cp = lo - 21'd1;
            1:       cp = lo;
            2:       cp = hi;
            3:       cp = hi + 21'd1;
            default: cp = lo + 21'($urandom_range(hi - lo));
        endcase
        append_char(cp, (cp > 21'h0FFFF) ? 4 : 3);
    endfunction

    function automatic void append_random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            append_char(21'($urandom_range(127)), 1);
        end else if (pick < 45) begin
            append_char(21'($urandom_range(2047)), 2);
        end else if (pick < 62) begin
            append_char(21'($urandom_range(65535)), 3);
        end else if (pick < 67) begin
            // Lead 0xED, with the second byte on either side of 0xA0.
            append_char(21'h0D000 | 21'($urandom_range(4095)), 3);
        end else if (pick < 78) begin
            append_char(21'($urandom_range(21'h1FFFFF)), 4);
        end else if (pick < 94) begin
            append_wide_char();
        end else begin
            // A raw byte: stray continuation, bad lead or a plain character.
            text_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    // Mostly well-formed texts with random content; the rest lose one or two
    // bytes from the end or have one byte replaced at random.
    task automatic run_random_text(input int byte_goal);
        int goal;
        int kind;
        int drop;
        goal = bytes_sent + byte_goal;
        while (bytes_sent < goal) begin
            repeat ($urandom_range(1, 8)) append_random_char();
            kind = $urandom_range(99);
            if (kind >= 75 && kind < 87 && text_q.size() > 1) begin
                drop = $urandom_range(1, 2);
                while (drop > 0 && text_q.size() > 1) begin
                    void'(text_q.pop_back());
                    drop--;
                end
            end else if (kind >= 87) begin
                text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
            end
            send_text();
        end
    endtask

    // The directed texts: each one ends with its final byte flagged.
    task automatic run_directed();
        // Field extremes, every sequence length, wide in three and four
        // bytes, with the final byte completing a character.
        text_q = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h98, 8'h83,
                   8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text();
        // Stray continuation where a lead belongs; later bytes are dropped
        // and the final byte carries the latched status.
        text_q = '{8'h80, 8'h41, 8'hFF};
        send_text();
        // Text that ends inside a three-byte sequence.
        text_q = '{8'hE2, 8'h82};
        send_text();
        // Surrogate half, found on the final byte itself.
        text_q = '{8'hED, 8'hA0};
        send_text();
        // Just below the surrogates: a valid character.
        text_q = '{8'hED, 8'h9F, 8'hBF};
        send_text();
        // Non-continuation after 0xED: the continuation check wins.
        text_q = '{8'hED, 8'h41};
        send_text();
        // Overlong form of zero, decoded as given.
        text_q = '{8'hC0, 8'h80};
        send_text();
        // A lone bad lead of the 11111xxx kind as the whole text.
        text_q = '{8'hF8};
        send_text();
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        cycles        = 0;
        bytes_sent    = 0;
        src_idle_pct  = 7;
        sink_idle_pct = 52;
        sb            = new();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        settle();

        // Receiver-limited traffic, then sender-limited, then full rate.
        run_random_text(275);
        settle();
        src_idle_pct  = 52;
        sink_idle_pct = 7;
        run_random_text(275);
        settle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random_text(275);
        settle();

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
